// ----- src/swm_pkg.sv -----
// Shared types and constants for the shifted-window mask generator.
// Used by swm_div12, swm_cfg and shifted_window_mask_relpos_gen.
`timescale 1ns / 1ps

package swm_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int MAX_GRID   = 64;
    localparam int DIV_STAGES = 12;
    localparam int BIAS_MAX   = 960;

    typedef enum logic [2:0] {
        REG_WINDOW_HEIGHT = 3'd0,
        REG_WINDOW_WIDTH  = 3'd1,
        REG_GRID_ROWS     = 3'd2,
        REG_GRID_COLS     = 3'd3,
        REG_SHIFT_ROWS    = 3'd4,
        REG_SHIFT_COLS    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [4:0]  window_height;
        logic [4:0]  window_width;
        logic [6:0]  grid_rows;
        logic [6:0]  grid_cols;
        logic [5:0]  shift_rows;
        logic [5:0]  shift_cols;
        logic [6:0]  win_cols;
        logic [13:0] win_count;
        logic [9:0]  ntok;
        logic [5:0]  stride;
        logic        cfg_err;
    } cfg_t;

endpackage

// ----- src/swm_div12.sv -----
// Pipelined restoring divider, 12-bit dividend by 7-bit divisor, one quotient bit per stage.
// Depends on swm_pkg; advances only when en is high.
`timescale 1ns / 1ps

module swm_div12 (
    input  logic        aclk,
    input  logic        en,
    input  logic [11:0] num,
    input  logic [6:0]  den,
    output logic [11:0] quo,
    output logic [6:0]  rem
);

    logic [6:0]  r_reg [swm_pkg::DIV_STAGES];
    logic [11:0] n_reg [swm_pkg::DIV_STAGES];
    logic [11:0] q_reg [swm_pkg::DIV_STAGES];
    logic [6:0]  d_reg [swm_pkg::DIV_STAGES];
    logic [6:0]  r_next [swm_pkg::DIV_STAGES];
    logic [11:0] n_next [swm_pkg::DIV_STAGES];
    logic [11:0] q_next [swm_pkg::DIV_STAGES];
    logic [6:0]  d_next [swm_pkg::DIV_STAGES];
    logic [6:0]  r_in  [swm_pkg::DIV_STAGES];
    logic [11:0] n_in  [swm_pkg::DIV_STAGES];
    logic [11:0] q_in  [swm_pkg::DIV_STAGES];
    logic [6:0]  d_in  [swm_pkg::DIV_STAGES];
    logic [7:0]  trial [swm_pkg::DIV_STAGES];

    always_comb begin
        for (int i = 0; i < swm_pkg::DIV_STAGES; i++) begin
            if (i == 0) begin
                r_in[i] = 7'd0;
                n_in[i] = num;
                q_in[i] = 12'd0;
                d_in[i] = den;
            end else begin
                r_in[i] = r_reg[i-1];
                n_in[i] = n_reg[i-1];
                q_in[i] = q_reg[i-1];
                d_in[i] = d_reg[i-1];
            end
            trial[i]  = {r_in[i], n_in[i][11]};
            n_next[i] = {n_in[i][10:0], 1'b0};
            d_next[i] = d_in[i];
            if (trial[i] >= {1'b0, d_in[i]}) begin
                r_next[i] = 7'(trial[i] - {1'b0, d_in[i]});
                q_next[i] = {q_in[i][10:0], 1'b1};
            end else begin
                r_next[i] = trial[i][6:0];
                q_next[i] = {q_in[i][10:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < swm_pkg::DIV_STAGES; i++) begin
                r_reg[i] <= r_next[i];
                n_reg[i] <= n_next[i];
                q_reg[i] <= q_next[i];
                d_reg[i] <= d_next[i];
            end
        end
    end

    assign quo = q_reg[swm_pkg::DIV_STAGES-1];
    assign rem = r_reg[swm_pkg::DIV_STAGES-1];

endmodule

// ----- src/swm_cfg.sv -----
// Configuration registers and derived window-grid quantities.
// Depends on swm_pkg and swm_div12.
`timescale 1ns / 1ps

module swm_cfg (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [6:0]   cfg_wdata,
    output swm_pkg::cfg_t cfg,
    output logic         busy
);

    localparam logic [3:0] SETTLE = 4'(swm_pkg::DIV_STAGES + 1);

    logic [4:0] wh_reg, ww_reg;
    logic [6:0] gr_reg, gc_reg;
    logic [5:0] sr_reg, sc_reg;
    logic [3:0] cnt_reg, cnt_next;
    logic [11:0] rq, cq;
    logic [6:0]  rr, cr;
    logic [6:0]  win_cols_reg;
    logic [13:0] win_count_reg;
    logic [9:0]  ntok_reg;
    logic [5:0]  stride_reg;
    logic        err_reg, err_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wh_reg <= 5'd7;
            ww_reg <= 5'd7;
            gr_reg <= 7'd56;
            gc_reg <= 7'd56;
            sr_reg <= 6'd3;
            sc_reg <= 6'd3;
        end else if (cfg_we) begin
            unique case (swm_pkg::cfg_reg_t'(cfg_index))
                swm_pkg::REG_WINDOW_HEIGHT: wh_reg <= cfg_wdata[4:0];
                swm_pkg::REG_WINDOW_WIDTH:  ww_reg <= cfg_wdata[4:0];
                swm_pkg::REG_GRID_ROWS:     gr_reg <= cfg_wdata;
                swm_pkg::REG_GRID_COLS:     gc_reg <= cfg_wdata;
                swm_pkg::REG_SHIFT_ROWS:    sr_reg <= cfg_wdata[5:0];
                swm_pkg::REG_SHIFT_COLS:    sc_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (cfg_we) begin
            cnt_next = SETTLE;
        end else if (cnt_reg != 4'd0) begin
            cnt_next = cnt_reg - 4'd1;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= SETTLE;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    swm_div12 u_div_rows (
        .aclk(aclk), .en(1'b1), .num({5'd0, gr_reg}), .den({2'd0, wh_reg}),
        .quo(rq), .rem(rr)
    );

    swm_div12 u_div_cols (
        .aclk(aclk), .en(1'b1), .num({5'd0, gc_reg}), .den({2'd0, ww_reg}),
        .quo(cq), .rem(cr)
    );

    always_comb begin
        err_next = (wh_reg == 5'd0) || (wh_reg > 5'(swm_pkg::MAX_WINDOW))
                || (ww_reg == 5'd0) || (ww_reg > 5'(swm_pkg::MAX_WINDOW))
                || (gr_reg == 7'd0) || (gr_reg > 7'(swm_pkg::MAX_GRID))
                || (gc_reg == 7'd0) || (gc_reg > 7'(swm_pkg::MAX_GRID))
                || (rr != 7'd0) || (cr != 7'd0)
                || ({1'b0, sr_reg} >= gr_reg) || ({1'b0, sc_reg} >= gc_reg);
    end

    always_ff @(posedge aclk) begin
        win_cols_reg  <= cq[6:0];
        win_count_reg <= rq[6:0] * cq[6:0];
        ntok_reg      <= wh_reg * ww_reg;
        stride_reg    <= 6'({1'b0, ww_reg, 1'b0} - 7'd1);
        err_reg       <= err_next;
    end

    always_comb begin
        cfg.window_height = wh_reg;
        cfg.window_width  = ww_reg;
        cfg.grid_rows     = gr_reg;
        cfg.grid_cols     = gc_reg;
        cfg.shift_rows    = sr_reg;
        cfg.shift_cols    = sc_reg;
        cfg.win_cols      = win_cols_reg;
        cfg.win_count     = win_count_reg;
        cfg.ntok          = ntok_reg;
        cfg.stride        = stride_reg;
        cfg.cfg_err       = err_reg;
    end

    assign busy = (cnt_reg != 4'd0);

endmodule

// ----- src/shifted_window_mask_relpos_gen.sv -----
// Top level of the shifted-window attention mask and relative position bias index generator.
// Depends on swm_pkg, swm_cfg and swm_div12.
`timescale 1ns / 1ps

// Takes one query/key pair per cycle while s_tready is high and returns the mask bit and the
// relative position bias index. The pipeline consists of two banks of 12-stage pipelined
// dividers (token and window coordinates, then original window coordinates) plus three
// arithmetic and output stages; all stages stall together when the result is not taken.
// After reset and after every configuration write, s_tready stays low while the window-grid
// dimensions are derived by the same kind of divider.
module shifted_window_mask_relpos_gen (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // window_index[11:0], query_token[19:12], key_token[27:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // masked[0], bias_index[10:1]
    output logic        m_tuser    // index_error
);

    localparam int N = swm_pkg::DIV_STAGES;

    swm_pkg::cfg_t cfg;
    logic busy, en, acc;

    logic [11:0] widx;
    logic [7:0]  qtok, ktok;
    logic        in_err;

    logic [11:0] aq_quo, ak_quo, aw_quo;
    logic [6:0]  aq_rem, ak_rem, aw_rem;
    logic        a_vld_reg [N];
    logic        a_err_reg [N];

    logic [5:0]  b1_srq_reg, b1_scq_reg, b1_srk_reg, b1_sck_reg;
    logic [4:0]  b1_dy_reg, b1_dx_reg;
    logic        b1_vld_reg, b1_err_reg;
    logic [5:0]  srq_next, scq_next, srk_next, sck_next;
    logic [4:0]  dy_next, dx_next;

    logic [6:0]  b2_orq_reg, b2_ocq_reg, b2_ork_reg, b2_ock_reg;
    logic [9:0]  b2_bias_reg;
    logic        b2_vld_reg, b2_err_reg;
    logic [6:0]  orq_next, ocq_next, ork_next, ock_next;

    logic [11:0] cqr_quo, cqc_quo, ckr_quo, ckc_quo;
    logic [6:0]  cqr_rem, cqc_rem, ckr_rem, ckc_rem;
    logic        c_vld_reg  [N];
    logic        c_err_reg  [N];
    logic [9:0]  c_bias_reg [N];

    logic        out_vld_reg, out_err_reg, out_mask_reg;
    logic [9:0]  out_bias_reg;

    function automatic logic [6:0] wrap(input logic [5:0] s, input logic [6:0] g,
                                        input logic [5:0] sh);
        logic [7:0] t;
        t = {2'd0, s} + {1'b0, g} - {2'd0, sh};
        if (t >= {1'b0, g}) begin
            t = t - {1'b0, g};
        end
        return t[6:0];
    endfunction

    swm_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .cfg(cfg), .busy(busy)
    );

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en && !busy;
    assign acc      = s_tvalid && s_tready;

    assign widx = s_tdata[11:0];
    assign qtok = s_tdata[19:12];
    assign ktok = s_tdata[27:20];
    assign in_err = cfg.cfg_err || ({2'd0, widx} >= cfg.win_count)
                 || ({2'd0, qtok} >= cfg.ntok) || ({2'd0, ktok} >= cfg.ntok);

    // token row/column and window row/column
    swm_div12 u_div_q (.aclk(aclk), .en(en), .num({4'd0, qtok}),
        .den({2'd0, cfg.window_width}), .quo(aq_quo), .rem(aq_rem));
    swm_div12 u_div_k (.aclk(aclk), .en(en), .num({4'd0, ktok}),
        .den({2'd0, cfg.window_width}), .quo(ak_quo), .rem(ak_rem));
    swm_div12 u_div_w (.aclk(aclk), .en(en), .num(widx),
        .den(cfg.win_cols), .quo(aw_quo), .rem(aw_rem));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                a_vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            a_vld_reg[0] <= acc;
            for (int i = 1; i < N; i++) begin
                a_vld_reg[i] <= a_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_err_reg[0] <= in_err;
            for (int i = 1; i < N; i++) begin
                a_err_reg[i] <= a_err_reg[i-1];
            end
        end
    end

    // shifted grid positions and offsets
    always_comb begin
        srq_next = 6'(aw_quo[5:0] * cfg.window_height + {2'd0, aq_quo[3:0]});
        srk_next = 6'(aw_quo[5:0] * cfg.window_height + {2'd0, ak_quo[3:0]});
        scq_next = 6'(aw_rem[5:0] * cfg.window_width + {2'd0, aq_rem[3:0]});
        sck_next = 6'(aw_rem[5:0] * cfg.window_width + {2'd0, ak_rem[3:0]});
        dy_next  = 5'({1'b0, aq_quo[3:0]} + cfg.window_height - 5'd1 - {1'b0, ak_quo[3:0]});
        dx_next  = 5'({1'b0, aq_rem[3:0]} + cfg.window_width - 5'd1 - {1'b0, ak_rem[3:0]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
        end else if (en) begin
            b1_vld_reg <= a_vld_reg[N-1];
            b2_vld_reg <= b1_vld_reg;
        end
    end

    always_comb begin
        orq_next = wrap(b1_srq_reg, cfg.grid_rows, cfg.shift_rows);
        ork_next = wrap(b1_srk_reg, cfg.grid_rows, cfg.shift_rows);
        ocq_next = wrap(b1_scq_reg, cfg.grid_cols, cfg.shift_cols);
        ock_next = wrap(b1_sck_reg, cfg.grid_cols, cfg.shift_cols);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_srq_reg  <= srq_next;
            b1_scq_reg  <= scq_next;
            b1_srk_reg  <= srk_next;
            b1_sck_reg  <= sck_next;
            b1_dy_reg   <= dy_next;
            b1_dx_reg   <= dx_next;
            b1_err_reg  <= a_err_reg[N-1];
            b2_orq_reg  <= orq_next;
            b2_ocq_reg  <= ocq_next;
            b2_ork_reg  <= ork_next;
            b2_ock_reg  <= ock_next;
            b2_bias_reg <= 10'(b1_dy_reg * cfg.stride + {5'd0, b1_dx_reg});
            b2_err_reg  <= b1_err_reg;
        end
    end

    // original window coordinates
    swm_div12 u_div_qr (.aclk(aclk), .en(en), .num({5'd0, b2_orq_reg}),
        .den({2'd0, cfg.window_height}), .quo(cqr_quo), .rem(cqr_rem));
    swm_div12 u_div_qc (.aclk(aclk), .en(en), .num({5'd0, b2_ocq_reg}),
        .den({2'd0, cfg.window_width}), .quo(cqc_quo), .rem(cqc_rem));
    swm_div12 u_div_kr (.aclk(aclk), .en(en), .num({5'd0, b2_ork_reg}),
        .den({2'd0, cfg.window_height}), .quo(ckr_quo), .rem(ckr_rem));
    swm_div12 u_div_kc (.aclk(aclk), .en(en), .num({5'd0, b2_ock_reg}),
        .den({2'd0, cfg.window_width}), .quo(ckc_quo), .rem(ckc_rem));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                c_vld_reg[i] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg[0] <= b2_vld_reg;
            for (int i = 1; i < N; i++) begin
                c_vld_reg[i] <= c_vld_reg[i-1];
            end
            out_vld_reg <= c_vld_reg[N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_err_reg[0]  <= b2_err_reg;
            c_bias_reg[0] <= b2_bias_reg;
            for (int i = 1; i < N; i++) begin
                c_err_reg[i]  <= c_err_reg[i-1];
                c_bias_reg[i] <= c_bias_reg[i-1];
            end
            out_err_reg  <= c_err_reg[N-1];
            out_mask_reg <= !c_err_reg[N-1]
                         && ((cqr_quo != ckr_quo) || (cqc_quo != ckc_quo));
            out_bias_reg <= c_err_reg[N-1] ? 10'd0 : c_bias_reg[N-1];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_bias_reg, out_mask_reg};
    assign m_tuser  = out_err_reg;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 16'd0))
        else $error("error result carries nonzero fields");

    a_busy_block: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready)
        else $error("input accepted while configuration settles");

    a_bias_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[10:1] <= 10'(swm_pkg::BIAS_MAX)))
        else $error("bias index out of range");

    a_cfg_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> busy)
        else $error("configuration write did not hold off input");

endmodule
